// ===== rtl/core/pbfl_pkg.sv =====
package pbfl_pkg;

  localparam int PBFL_DEPTH = 1024;

  localparam int IDX_W   = 10;
  localparam int PROD_W  = 48;
  localparam int FRAC_W  = 31;
  localparam int LAM_W   = 32;
  localparam int TEMP_W  = 24;
  localparam int XP_W    = 52;   // lambda*T after the right shift by 4
  localparam int RES_W   = 32;
  localparam int CFG_W   = 11;
  localparam int DIVD_W  = 63;
  localparam int DIVS_W  = 32;
  localparam int QUO_W   = 31;

  localparam logic [RES_W-1:0]  ONE_Q30 = 32'h4000_0000;
  localparam logic [TEMP_W-1:0] T_FLOOR = 24'd694;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_SINGLE_BAND  = 1'b0;
  localparam logic CFG_ENTRIES_USED = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHECK,
    S_EVAL,
    S_SRCH,
    S_SCMP,
    S_RD_I1,
    S_SEG,
    S_NORM,
    S_MUL,
    S_DIVST,
    S_DIVW,
    S_PUT
  } state_t;

endpackage

// ===== rtl/core/pbfl_div.sv =====
module pbfl_div
  import pbfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  // Quotient is known to fit QUO_W bits, so the top half starts below the divisor.
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  num_r, num_nxt;
  logic [DIVS_W-1:0] dsr_r, dsr_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[QUO_W-1]};
    diff     = trial - {1'b0, dsr_r};
    if (start) begin
      rem_nxt  = dividend[DIVD_W-1:QUO_W];
      num_nxt  = dividend[QUO_W-1:0];
      dsr_nxt  = divisor;
      cnt_nxt  = 5'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DIVS_W-1:0];
        num_nxt = {num_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        num_nxt = {num_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ===== rtl/core/planck_band_fraction_lookup.sv =====
// Blackbody band fraction from a loaded lambda*T table.
//
// Input channel in_*: in_tuser carries the opcode. A write item stores one
// table entry and gives no result; a query item gives one band_fraction on
// out_*, F(lambda_high*T) - F(lambda_low*T) with linear interpolation.
// Configuration (cfg_we/cfg_addr/cfg_wdata) sets single_band and
// entries_used; write it only while the block is idle.
//
// A write item is taken in its transfer cycle and the block stays
// ready. A query holds in_tready low until its result is in the output
// register: setup forms both lambda*T products, reads the first and last
// entries and checks the band; then each band end inside the table is
// located by binary search (ten steps at 1024 entries), its segment fetched
// and normalized, then multiplied and divided on the shared restoring
// divider, before the result goes to the output register. Flat segments
// skip the divider; single-band queries and bands wholly outside the table
// skip the per-end work. One query is worked at a time.
//
// Reset clears control state and the registers (single_band 0,
// entries_used 1024); table contents stay undefined until written.
// The result waits in an output register: a stalled receiver holds it while
// the next item is already accepted, and a finished query waits for it.
module planck_band_fraction_lookup
  import pbfl_pkg::*;
#(
  parameter int TABLE_DEPTH = PBFL_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // entry_index[9:0], entry_product[57:10], entry_fraction[88:58],
  // lambda_low[120:89], lambda_high[152:121], temperature_k[176:153], zero pad
  input  logic [183:0]      in_tdata,
  // opcode[0]
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // band_fraction[31:0], signed Q1.30
  output logic [RES_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Unpack the input transfer
  logic [IDX_W-1:0]  f_idx;
  logic [PROD_W-1:0] f_prod;
  logic [FRAC_W-1:0] f_frac;
  logic [LAM_W-1:0]  f_llo;
  logic [LAM_W-1:0]  f_lhi;
  logic [TEMP_W-1:0] f_temp;

  assign f_idx  = in_tdata[9:0];
  assign f_prod = in_tdata[57:10];
  assign f_frac = in_tdata[88:58];
  assign f_llo  = in_tdata[120:89];
  assign f_lhi  = in_tdata[152:121];
  assign f_temp = in_tdata[176:153];

  // Configuration
  logic             single_r;
  logic [CFG_W-1:0] eused_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_r <= 1'b0;
      eused_r  <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SINGLE_BAND:  single_r <= cfg_wdata[0];
        CFG_ENTRIES_USED: eused_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Table memory: one write port, one registered read port
  logic [PROD_W-1:0] product_mem [TABLE_DEPTH];
  logic [FRAC_W-1:0] fraction_mem [TABLE_DEPTH];
  logic [PROD_W-1:0] rd_p_r;
  logic [FRAC_W-1:0] rd_f_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      product_mem[AW'(f_idx)]  <= f_prod;
      fraction_mem[AW'(f_idx)] <= f_frac;
    end
    rd_p_r <= product_mem[rd_addr];
    rd_f_r <= fraction_mem[rd_addr];
  end

  // Sequencer registers
  state_t            state_r, state_nxt;
  logic [LAM_W-1:0]  llo_r, llo_nxt;
  logic [LAM_W-1:0]  lhi_r, lhi_nxt;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic [XP_W-1:0]   ltmin_r, ltmin_nxt;
  logic [XP_W-1:0]   ltmax_r, ltmax_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [PROD_W-1:0] first_p_r, first_p_nxt;
  logic [FRAC_W-1:0] first_f_r, first_f_nxt;
  logic [PROD_W-1:0] last_p_r, last_p_nxt;
  logic              phase_r, phase_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [PROD_W-1:0] p0_r, p0_nxt;
  logic [FRAC_W-1:0] f0_r, f0_nxt;
  logic [PROD_W-1:0] w_r, w_nxt;
  logic [PROD_W-1:0] off_r, off_nxt;
  logic [FRAC_W-1:0] d_r, d_nxt;
  logic [FRAC_W-1:0] base_r, base_nxt;
  logic              neg_r, neg_nxt;
  logic [DIVD_W-1:0] prod_r, prod_nxt;
  logic [RES_W-1:0]  pmin_r, pmin_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [RES_W-1:0]  odata_r, odata_nxt;

  // Shared divider
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_q;

  pbfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (w_r[DIVS_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Combinational helpers
  logic [XP_W-1:0]    x;
  logic [55:0]        mul_lt;
  logic [AW:0]        mid_sum;
  logic [CW-1:0]      n_sel;
  logic [XP_W-1:0]    seg_off;
  logic [PROD_W-1:0]  seg_w;
  logic               fin_en;
  logic [RES_W-1:0]   fin_val;
  logic [TEMP_W-1:0]  t_clamp;

  assign x       = phase_r ? ltmax_r : ltmin_r;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (AW + 1)'(1);
  assign t_clamp = (f_temp < T_FLOOR) ? T_FLOOR : f_temp;
  assign seg_w   = rd_p_r - p0_r;
  assign seg_off = (x > {4'b0, p0_r}) ? x - {4'b0, p0_r} : '0;

  always_comb begin
    if (32'(eused_r) < 32'd2) begin
      n_sel = CW'(2);
    end else if (32'(eused_r) > 32'(TABLE_DEPTH)) begin
      n_sel = CW'(TABLE_DEPTH);
    end else begin
      n_sel = CW'(eused_r);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    llo_nxt     = llo_r;
    lhi_nxt     = lhi_r;
    temp_nxt    = temp_r;
    ltmin_nxt   = ltmin_r;
    ltmax_nxt   = ltmax_r;
    n_nxt       = n_r;
    first_p_nxt = first_p_r;
    first_f_nxt = first_f_r;
    last_p_nxt  = last_p_r;
    phase_nxt   = phase_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    p0_nxt      = p0_r;
    f0_nxt      = f0_r;
    w_nxt       = w_r;
    off_nxt     = off_r;
    d_nxt       = d_r;
    base_nxt    = base_r;
    neg_nxt     = neg_r;
    prod_nxt    = prod_r;
    pmin_nxt    = pmin_r;
    res_nxt     = res_r;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;
    in_tready   = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = '0;
    div_start   = 1'b0;
    fin_en      = 1'b0;
    fin_val     = '0;
    mul_lt      = '0;

    // Drop the output once the receiver takes it
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_WRITE) begin
            mem_we = (32'(f_idx) < 32'(TABLE_DEPTH));
          end else begin
            llo_nxt  = f_llo;
            lhi_nxt  = f_lhi;
            temp_nxt = t_clamp;
            n_nxt    = n_sel;
            if (single_r) begin
              res_nxt   = ONE_Q30;
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_MUL_LO;
            end
          end
        end
      end
      S_MUL_LO: begin
        mul_lt    = llo_r * temp_r;
        ltmin_nxt = mul_lt[55:4];
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        mul_lt    = lhi_r * temp_r;
        ltmax_nxt = mul_lt[55:4];
        state_nxt = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        rd_addr   = '0;
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        first_p_nxt = rd_p_r;
        first_f_nxt = rd_f_r;
        rd_addr     = AW'(n_r - CW'(1));
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        last_p_nxt = rd_p_r;
        phase_nxt  = 1'b0;
        // Band wholly below or wholly above the table
        if ((ltmin_r < {4'b0, first_p_r} && ltmax_r < {4'b0, first_p_r}) ||
            (ltmax_r > {4'b0, rd_p_r} && ltmin_r > {4'b0, rd_p_r})) begin
          res_nxt   = ONE_Q30;
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!phase_r && x < {4'b0, first_p_r}) begin
          // Low ramp from zero up to the first entry
          d_nxt     = first_f_r;
          off_nxt   = x[PROD_W-1:0];
          w_nxt     = first_p_r;
          base_nxt  = '0;
          neg_nxt   = 1'b0;
          state_nxt = S_NORM;
        end else if (phase_r && x > {4'b0, last_p_r}) begin
          fin_en  = 1'b1;
          fin_val = ONE_Q30;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = AW'(n_r - CW'(2));
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid_sum[AW:1];
          mid_nxt   = mid_sum[AW:1];
          state_nxt = S_SCMP;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_RD_I1;
        end
      end
      S_SCMP: begin
        if ({4'b0, rd_p_r} <= x) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - AW'(1);
        end
        state_nxt = S_SRCH;
      end
      S_RD_I1: begin
        p0_nxt    = rd_p_r;
        f0_nxt    = rd_f_r;
        rd_addr   = lo_r + AW'(1);
        state_nxt = S_SEG;
      end
      S_SEG: begin
        if (rd_p_r <= p0_r) begin
          // Flat segment
          fin_en  = 1'b1;
          fin_val = {1'b0, f0_r};
        end else begin
          w_nxt    = seg_w;
          off_nxt  = (seg_off > {4'b0, seg_w}) ? seg_w : seg_off[PROD_W-1:0];
          base_nxt = f0_r;
          if (rd_f_r >= f0_r) begin
            d_nxt   = rd_f_r - f0_r;
            neg_nxt = 1'b0;
          end else begin
            d_nxt   = f0_r - rd_f_r;
            neg_nxt = 1'b1;
          end
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // Halve width and offset until the width fits the divisor
        if (w_r[PROD_W-1:DIVS_W] != '0) begin
          w_nxt   = w_r >> 1;
          off_nxt = off_r >> 1;
        end else if (w_r == '0) begin
          fin_en  = 1'b1;
          fin_val = {1'b0, base_r};
        end else begin
          if (off_r > w_r) begin
            off_nxt = w_r;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = d_r * off_r[DIVS_W-1:0];
        state_nxt = S_DIVST;
      end
      S_DIVST: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          fin_en  = 1'b1;
          fin_val = neg_r ? ({1'b0, base_r} - {1'b0, div_q}) :
                            ({1'b0, base_r} + {1'b0, div_q});
        end
      end
      S_PUT: begin
        // Hold the result until the output register frees up
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Close one side of the band
    if (fin_en) begin
      if (!phase_r) begin
        pmin_nxt  = fin_val;
        phase_nxt = 1'b1;
        state_nxt = S_EVAL;
      end else begin
        res_nxt   = fin_val - pmin_r;
        state_nxt = S_PUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    llo_r     <= llo_nxt;
    lhi_r     <= lhi_nxt;
    temp_r    <= temp_nxt;
    ltmin_r   <= ltmin_nxt;
    ltmax_r   <= ltmax_nxt;
    n_r       <= n_nxt;
    first_p_r <= first_p_nxt;
    first_f_r <= first_f_nxt;
    last_p_r  <= last_p_nxt;
    phase_r   <= phase_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    p0_r      <= p0_nxt;
    f0_r      <= f0_nxt;
    w_r       <= w_nxt;
    off_r     <= off_nxt;
    d_r       <= d_nxt;
    base_r    <= base_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    pmin_r    <= pmin_nxt;
    res_r     <= res_nxt;
    odata_r   <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

`ifndef SYNTH
  // Search window never inverts
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (lo_r <= hi_r))
    else $error("search window inverted");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider done outside wait state");

  // A table write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_WRITE) |=> !$rose(out_tvalid))
    else $error("result after table write");
`endif

endmodule

// ===== sim/planck_band_fraction_lookup_test.sv =====
module planck_band_fraction_lookup_test;
  import pbfl_pkg::*;

  localparam int  DEPTH       = PBFL_DEPTH;
  localparam int  SETTLE_CYC  = 200;     // longer than the slowest query
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  QUIET_ITEMS = 60;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [9:0]  idx;
    logic [47:0] prod;
    logic [30:0] frac;
    logic [31:0] lam_lo;
    logic [31:0] lam_hi;
    logic [23:0] temp;
    logic        cfg_reg;
    logic [10:0] cfg_val;
    bit          has_exp;
    logic [31:0] exp_val;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [183:0]     in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [RES_W-1:0] out_tdata;
  logic             cfg_we;
  logic             cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state: its own copy of the table and of the registers
  logic [47:0] prod_mem [DEPTH];
  logic [30:0] frac_mem [DEPTH];
  logic        single_band_q;
  logic [10:0] entries_used_q;

  logic [31:0] expected_fractions [$];
  row_t        directed_rows [$];

  int  mismatches = 0;
  int  queries_sent = 0;
  int  writes_sent = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  idle_pct = 0;      // chance in percent of an idle burst per item
  bit  quiet = 1'b0;      // no idling on either side
  int  out_stall_left = 0;
  int  in_burst;

  planck_band_fraction_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int live_entries();
    int n;
    n = entries_used_q;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // d * off / w, halving w and off until w fits in 32 bits
  function automatic bit [63:0] scaled_step(bit [63:0] d, bit [63:0] off, bit [63:0] w);
    while (w >= 64'h1_0000_0000) begin
      w = w >> 1;
      off = off >> 1;
    end
    if (w == 0) return 0;
    if (off > w) off = w;
    return (d * off) / w;
  endfunction

  // largest segment start in [0, n-2] whose product is <= x, else 0
  function automatic int segment_of(bit [63:0] x, int n);
    int lo, hi, mid;
    lo = 0;
    hi = n - 2;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (64'(prod_mem[mid]) <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit [63:0] cumulative_at(bit [63:0] x, int n);
    int i;
    bit [63:0] p0, p1, f0, f1, w, off;
    i = segment_of(x, n);
    p0 = prod_mem[i];
    p1 = prod_mem[i+1];
    f0 = frac_mem[i];
    f1 = frac_mem[i+1];
    if (p1 <= p0) return f0;        // flat segment
    w = p1 - p0;
    off = (x > p0) ? x - p0 : 0;
    if (off > w) off = w;
    if (f1 >= f0) return f0 + scaled_step(f1 - f0, off, w);
    return f0 - scaled_step(f0 - f1, off, w);
  endfunction

  function automatic logic [31:0] band_fraction_of(logic [31:0] lam_lo, logic [31:0] lam_hi,
                                                   logic [23:0] temp);
    int n;
    bit [63:0] first_p, last_p, t, x_lo, x_hi, f_lo, f_hi;
    n = live_entries();
    first_p = prod_mem[0];
    last_p = prod_mem[n-1];
    if (single_band_q) return ONE_Q30;
    t = (temp < T_FLOOR) ? 64'(T_FLOOR) : 64'(temp);
    x_lo = (64'(lam_lo) * t) >> 4;
    x_hi = (64'(lam_hi) * t) >> 4;
    if (x_lo < first_p) begin
      f_lo = scaled_step(frac_mem[0], x_lo, first_p);    // low ramp from zero
      if (x_hi < first_p) return ONE_Q30;                // band below the table
    end else begin
      f_lo = cumulative_at(x_lo, n);
    end
    if (x_hi > last_p) begin
      f_hi = 64'(ONE_Q30);
      if (x_lo > last_p) return ONE_Q30;                 // band above the table
    end else begin
      f_hi = cumulative_at(x_hi, n);
    end
    return 32'(f_hi - f_lo);
  endfunction

  // append one expectation to the scoreboard
  function automatic void note_expected(logic [31:0] v);
    expected_fractions = {expected_fractions, v};
  endfunction

  function automatic void add_row(row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // ---------------------------------------------------------------- driving
  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_WRITE;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_SINGLE_BAND;
    cfg_wdata <= '0;
  end

  // Present one transfer and hold it until accepted; the expectation is
  // worked out at acceptance, so the predictor sees writes in block order.
  task automatic send_item(row_t r);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= (r.kind == ROW_QUERY) ? OP_QUERY : OP_WRITE;
    in_tdata <= {7'd0, r.temp, r.lam_hi, r.lam_lo, r.frac, r.prod, r.idx};
    do @(posedge clk); while (!in_tready);
    if (r.kind == ROW_QUERY) begin
      note_expected(r.has_exp ? r.exp_val : band_fraction_of(r.lam_lo, r.lam_hi, r.temp));
      queries_sent++;
    end else begin
      prod_mem[r.idx] = r.prod;
      frac_mem[r.idx] = r.frac;
      writes_sent++;
    end
  endtask

  // Drain the block, then write one register.
  task automatic write_register(logic which, logic [10:0] value);
    in_tvalid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_SINGLE_BAND) single_band_q = value[0];
    else entries_used_q = value;
  endtask

  task automatic run_row(row_t r);
    if (r.kind == ROW_CFG) write_register(r.cfg_reg, r.cfg_val);
    else send_item(r);
  endtask

  function automatic row_t mk_write(int idx, bit [47:0] p, bit [30:0] f);
    row_t r;
    r = '{kind: ROW_WRITE, idx: 10'(idx), prod: p, frac: f, default: '0};
    r.lam_lo = $urandom;      // don't-care fields still toggle
    r.lam_hi = $urandom;
    r.temp = 24'($urandom);
    return r;
  endfunction

  function automatic row_t mk_query(bit [31:0] lo, bit [31:0] hi, bit [23:0] t,
                                    bit has_exp = 0, bit [31:0] ev = 0);
    row_t r;
    r = '{kind: ROW_QUERY, lam_lo: lo, lam_hi: hi, temp: t, has_exp: has_exp,
          exp_val: ev, default: '0};
    r.idx = 10'($urandom);
    r.prod = 48'({$urandom, $urandom});
    r.frac = 31'($urandom);
    return r;
  endfunction

  function automatic row_t mk_cfg(logic which, bit [10:0] v);
    row_t r;
    r = '{kind: ROW_CFG, cfg_reg: which, cfg_val: v, default: '0};
    return r;
  endfunction

  // Fill entries 0..n-1, mostly ascending, with flat and backward steps now and then.
  task automatic load_table(int n);
    bit [63:0] p, f, step;
    int k;
    p = 64'd1 << $urandom_range(10, 40);
    f = $urandom_range(0, 1 << 28);
    for (k = 0; k < n; k++) begin
      send_item(mk_write(k, (p > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : p[47:0],
                         ($urandom_range(0, 19) == 0) ? 31'($urandom) : f[30:0]));
      case ($urandom_range(0, 9))
        0:       step = 0;
        1:       p = (p > 64'd4096) ? p - $urandom_range(1, 4096) : p;
        default: step = $urandom_range(1, 1000) * (64'd1 << $urandom_range(0, 30));
      endcase
      p = p + step;
      step = 0;
      if (f < 64'(ONE_Q30))
        f = f + $urandom_range(0, 32'(((64'(ONE_Q30) - f) / 64'(n - k)) * 2));
      if (f > 64'(ONE_Q30)) f = ONE_Q30;
    end
  endtask

  task automatic random_item(int n);
    bit [63:0] x, t, lam;
    bit [31:0] lo, hi, sw;
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 15) begin
      send_item(mk_write((dice < 10) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH - 1),
                         48'({$urandom, $urandom}), 31'($urandom)));
    end else if (dice < 25) begin
      send_item(mk_query($urandom, $urandom, 24'($urandom)));    // raw noise
    end else begin
      // aim both ends near table entries so the search and the divider work
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 800) : $urandom_range(694, 24'hFF_FFFF);
      if (t < T_FLOOR) t = T_FLOOR;
      x = prod_mem[$urandom_range(0, n - 1)] + $urandom_range(0, 1 << $urandom_range(0, 31));
      lam = (x << 4) / t;
      lo = (lam > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lam[31:0];
      x = prod_mem[$urandom_range(0, n - 1)] + $urandom_range(0, 1 << $urandom_range(0, 31));
      lam = (x << 4) / t;
      hi = (lam > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lam[31:0];
      if ((lo > hi) == ($urandom_range(0, 4) != 0)) begin
        sw = lo;
        lo = hi;
        hi = sw;
      end
      send_item(mk_query(lo, hi, ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 693))
                                                             : t[23:0]));
    end
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial out_tready <= 1'b0;

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_fractions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result band_fraction=%h", out_tdata);
      end else begin
        if (out_tdata !== expected_fractions[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("band_fraction mismatch: expected %h actual %h",
                     expected_fractions[0], out_tdata);
        end
        void'(expected_fractions.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int ph, k, n, per_phase;
    int used_settings [9];
    int idle_settings [9];

    used_settings = '{2, 1, 3, 9, 37, 64, 5, 0, 17};
    idle_settings = '{25, 0, 50, 25, 10, 40, 0, 25, 0};
    for (k = 0; k < DEPTH; k++) begin
      prod_mem[k] = '0;
      frac_mem[k] = '0;
    end
    single_band_q = 1'b0;
    entries_used_q = 11'd1024;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a four-entry table, T = 4096 K gives lambda*T >> 4 = lambda * 256.
    add_row(mk_cfg(CFG_ENTRIES_USED, 11'd4));
    add_row(mk_write(0, 48'd1 << 30, 31'h0100_0000));
    add_row(mk_write(1, 48'd1 << 32, 31'h1000_0000));
    add_row(mk_write(2, 48'd1 << 34, 31'h3000_0000));
    add_row(mk_write(3, 48'd1 << 36, 31'h4000_0000));
    add_row(mk_query(0, 0, 0, 1, ONE_Q30));                     // below table
    add_row(mk_query('1, '1, '1, 1, ONE_Q30));                   // above table
    add_row(mk_query(0, '1, '1, 1, ONE_Q30));                    // whole range
    add_row(mk_query(32'd1 << 21, 32'd3 << 21, 24'd4096));       // ramp into seg 0
    add_row(mk_query(32'd1 << 22, 32'd1 << 28, 24'd4096));       // exact ends
    add_row(mk_query(32'd5 << 23, 32'd3 << 26, 24'd4096));       // inside segments
    add_row(mk_query(32'd1 << 26, 32'd1 << 23, 24'd4096));       // reversed band
    add_row(mk_query(32'd1 << 25, 32'h7FFF_FFFF, 24'd1));        // floored T, top open
    add_row(mk_write(1023, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF));  // field extremes
    add_row(mk_cfg(CFG_SINGLE_BAND, 11'd1));
    add_row(mk_query(32'd1 << 22, 32'd1 << 24, 24'd4096, 1, ONE_Q30));
    add_row(mk_cfg(CFG_SINGLE_BAND, 11'd0));
    add_row(mk_cfg(CFG_ENTRIES_USED, 11'd0));                     // acts as two
    add_row(mk_query(32'd3 << 21, 32'd3 << 22, 24'd4096));
    foreach (directed_rows[i]) run_row(directed_rows[i]);

    // Random: each phase sets the registers, reloads the live entries, then mixes traffic.
    per_phase = 25;
    for (ph = 0; ph < 9; ph++) begin
      idle_pct = idle_settings[ph];
      write_register(CFG_SINGLE_BAND, (ph == 4) ? 11'd1 : 11'd0);
      write_register(CFG_ENTRIES_USED, 11'(used_settings[ph]));
      n = live_entries();
      load_table(n);
      for (k = 0; k < per_phase; k++) begin
        if (ph == 8 && k >= per_phase - QUIET_ITEMS / 2) quiet = 1'b1;
        random_item(n);
      end
    end
    quiet = 1'b1;
    for (k = 0; k < QUIET_ITEMS / 2; k++) random_item(live_entries());
    in_tvalid <= 1'b0;

    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_fractions.size() != 0) mismatches++;

    $display("covered %0d band queries and %0d table writes, %0d results checked",
             queries_sent, writes_sent, results_seen);
    $display("entry counts 0 to 64, single-band on and off, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
